FILE: sv/sfr_pkg.sv
// shared types and constants for the stream find-and-replace block
package sfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 4;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 2;
    localparam int USER_W          = 2;
    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPLACE_MAX_DEF = 8;
    localparam int QUEUE_DEPTH     = 2;

    // bit positions inside the master tuser
    localparam int USER_PRESENT = 0;
    localparam int USER_DONE    = 1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1,
        CFG_REPLACE_BYTES  = 2'd2,
        CFG_REPLACE_LENGTH = 2'd3
    } t_cfg_reg;

    // flags carried with each queued job
    typedef struct packed {
        logic fin;
        logic present;
    } t_job_flags;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: sv/stream_find_replace.sv
// top level of the stream find-and-replace block
//
//  channel   dir  payload                                   handshake
//  s_axis    in   tdata = in_byte, tlast = in_final         tvalid / tready
//  m_axis    out  tdata = out_byte, tlast = run_last,       tvalid / tready
//                 tuser = {stream_done, byte_present}
//  cfg       in   index + 64-bit data, write on i_cfg_we    no wait, no read-back
//
//  an input beat is taken when the job queue has room; an input beat that yields n result
//  bytes gives n result beats, one result beat per cycle while the receiver is ready
//  rate is set by the single-byte output register fed from the two-entry job queue
//  each job passes from the job queue into the output register
//  reset is synchronous and clears configuration, pending count, queue and output
//  the front keeps taking beats while the queue has room, even with the output stalled
module stream_find_replace #(
    parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sfr_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] in_byte
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sfr_pkg::BYTE_W-1:0]       m_axis_tdata,   // [7:0] out_byte
    output logic                             m_axis_tlast,
    output logic [sfr_pkg::USER_W-1:0]       m_axis_tuser    // [0] byte_present, [1] stream_done
);
    import sfr_pkg::*;

    localparam int JOB_MAX = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
    localparam int JCW     = $clog2(JOB_MAX + 1);
    localparam int FLAG_W  = $bits(t_job_flags);
    localparam int JOB_W   = JOB_MAX * BYTE_W + JCW + FLAG_W;

    logic                      push;
    logic                      pop;
    t_q_status                 q_status;
    logic [JOB_MAX*BYTE_W-1:0] f_bytes;
    logic [JCW-1:0]            f_count;
    t_job_flags                f_flags;
    logic [JOB_MAX*BYTE_W-1:0] b_bytes;
    logic [JCW-1:0]            b_count;
    t_job_flags                b_flags;
    logic [JOB_W-1:0]          q_head;

    // front: classify each beat and build its job
    sfr_front #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX),
        .JOB_MAX     (JOB_MAX),
        .JCW         (JCW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .i_byte      (s_axis_tdata),
        .i_final     (s_axis_tlast),
        .o_ready     (s_axis_tready),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_job_bytes (f_bytes),
        .o_job_count (f_count),
        .o_job_flags (f_flags)
    );

    // job queue
    sfr_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   ({f_flags, f_count, f_bytes}),
        .i_pop    (pop),
        .o_data   (q_head),
        .o_status (q_status)
    );

    assign {b_flags, b_count, b_bytes} = q_head;

    // back: serialise jobs into result beats
    sfr_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX),
        .JOB_MAX     (JOB_MAX),
        .JCW         (JCW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_job_bytes (b_bytes),
        .i_job_count (b_count),
        .i_job_flags (b_flags),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .o_user      (m_axis_tuser)
    );

endmodule

FILE: sv/sfr_front.sv
// front part: configuration registers, pending window, match and job building
module sfr_front #(
    parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF,
    parameter int JOB_MAX     = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX,
    parameter int JCW         = $clog2(JOB_MAX + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_valid,
    input  logic [sfr_pkg::BYTE_W-1:0]          i_byte,
    input  logic                                i_final,
    output logic                                o_ready,
    input  sfr_pkg::t_q_status                  i_q_status,
    output logic                                o_push,
    output logic [JOB_MAX*sfr_pkg::BYTE_W-1:0]  o_job_bytes,
    output logic [JCW-1:0]                      o_job_count,
    output sfr_pkg::t_job_flags                 o_job_flags
);
    import sfr_pkg::*;

    localparam int WCW = $clog2(PATTERN_MAX + 1);
    localparam int RCW = $clog2(REPLACE_MAX + 1);

    logic [CFG_DATA_W-1:0] r_pat;
    logic [LEN_W-1:0]      r_plen;
    logic [CFG_DATA_W-1:0] r_rep;
    logic [LEN_W-1:0]      r_rlen;

    logic [BYTE_W-1:0] r_win [PATTERN_MAX];
    logic [BYTE_W-1:0] n_win [PATTERN_MAX];
    logic [WCW-1:0]    r_cnt;
    logic [WCW-1:0]    n_cnt;

    logic [BYTE_W-1:0] ext [PATTERN_MAX];
    logic [WCW-1:0]    plen;
    logic [RCW-1:0]    rlen;
    logic [WCW-1:0]    tot;
    logic [WCW-1:0]    k;
    logic              match;
    logic              use_rep;
    logic              accept;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= '0;
            r_rep  <= '0;
            r_rlen <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_PATTERN_BYTES:  r_pat  <= i_cfg_wdata;
                CFG_PATTERN_LENGTH: r_plen <= i_cfg_wdata[LEN_W-1:0];
                CFG_REPLACE_BYTES:  r_rep  <= i_cfg_wdata;
                CFG_REPLACE_LENGTH: r_rlen <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;

    // saturated lengths and the window extended by the new byte
    always_comb begin
        plen = (r_plen > LEN_W'(PATTERN_MAX)) ? WCW'(PATTERN_MAX) : WCW'(r_plen);
        rlen = (r_rlen > LEN_W'(REPLACE_MAX)) ? RCW'(REPLACE_MAX) : RCW'(r_rlen);
        tot  = r_cnt + WCW'(1);
        for (int i = 0; i < PATTERN_MAX; i++) begin
            ext[i] = (WCW'(i) < r_cnt) ? r_win[i] : i_byte;
        end
    end

    // compare full window against the pattern
    always_comb begin
        match = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (WCW'(i) < plen && ext[i] != r_pat[i*BYTE_W +: BYTE_W]) begin
                match = 1'b0;
            end
        end
    end

    // classify: how many bytes drain, or replace
    always_comb begin
        use_rep = 1'b0;
        k       = '0;
        if (plen == '0) begin
            k = tot;
        end else if (tot > plen) begin
            k = tot - plen + WCW'(1);
        end else if (tot == plen) begin
            if (match) begin
                use_rep = 1'b1;
            end else begin
                k = WCW'(1);
            end
        end
        if (i_final && !use_rep) begin
            k = tot;
        end
    end

    // next window contents after draining k bytes
    always_comb begin
        n_cnt = use_rep ? '0 : (tot - k);
        for (int i = 0; i < PATTERN_MAX; i++) begin
            n_win[i] = ext[i];
            for (int s = 0; s < PATTERN_MAX; s++) begin
                if (i + s < PATTERN_MAX && k == WCW'(s)) begin
                    n_win[i] = ext[i+s];
                end
            end
        end
    end

    // job towards the queue
    always_comb begin
        logic [JCW-1:0] n_bytes;
        n_bytes = use_rep ? JCW'(rlen) : JCW'(k);
        for (int j = 0; j < JOB_MAX; j++) begin
            if (use_rep) begin
                o_job_bytes[j*BYTE_W +: BYTE_W] =
                    (j < REPLACE_MAX) ? r_rep[j*BYTE_W +: BYTE_W] : '0;
            end else begin
                o_job_bytes[j*BYTE_W +: BYTE_W] = (j < PATTERN_MAX) ? ext[j] : '0;
            end
        end
        o_job_flags.present = (n_bytes != '0);
        o_job_flags.fin     = i_final;
        o_job_count         = (n_bytes != '0) ? n_bytes : JCW'(1);
        o_push              = accept && ((n_bytes != '0) || i_final);
    end

    // pending count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
    end

    // pending bytes
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

endmodule

FILE: sv/sfr_queue.sv
// short job queue between the front and the back
module sfr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sfr_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output sfr_pkg::t_q_status o_status
);
    import sfr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;

    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_data         = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: sv/sfr_back.sv
// back part: walks the head job one byte per beat into the output register
module sfr_back #(
    parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF,
    parameter int JOB_MAX     = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX,
    parameter int JCW         = $clog2(JOB_MAX + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sfr_pkg::t_q_status                  i_q_status,
    input  logic [JOB_MAX*sfr_pkg::BYTE_W-1:0]  i_job_bytes,
    input  logic [JCW-1:0]                      i_job_count,
    input  sfr_pkg::t_job_flags                 i_job_flags,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sfr_pkg::BYTE_W-1:0]          o_data,
    output logic                                o_last,
    output logic [sfr_pkg::USER_W-1:0]          o_user
);
    import sfr_pkg::*;

    logic [JCW-1:0]    r_idx;
    logic              r_valid;
    logic [BYTE_W-1:0] r_data;
    logic              r_last;
    logic [USER_W-1:0] r_user;
    logic [USER_W-1:0] n_user;

    logic              load;
    logic              is_last;
    logic [BYTE_W-1:0] sel_byte;

    // pick the current byte of the head job
    always_comb begin
        sel_byte = '0;
        for (int j = 0; j < JOB_MAX; j++) begin
            if (r_idx == JCW'(j)) begin
                sel_byte = i_job_bytes[j*BYTE_W +: BYTE_W];
            end
        end
        if (!i_job_flags.present) begin
            sel_byte = '0;
        end
        is_last = (r_idx + JCW'(1) == i_job_count);
        load    = (!r_valid || i_ready) && !i_q_status.empty;
        o_pop   = load && is_last;
        n_user               = '0;
        n_user[USER_PRESENT] = i_job_flags.present;
        n_user[USER_DONE]    = is_last && i_job_flags.fin;
    end

    // byte index within the head job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (load) begin
            r_idx <= is_last ? '0 : r_idx + JCW'(1);
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= sel_byte;
            r_last <= is_last;
            r_user <= n_user;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;
    assign o_user  = r_user;

endmodule

FILE: sv/sfr_checker.sv
// port-level checks for the stream find-and-replace block, bound to the top level
module sfr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sfr_pkg::BYTE_W-1:0]      m_axis_tdata,
    input logic                            m_axis_tlast,
    input logic [sfr_pkg::USER_W-1:0]      m_axis_tuser
);
    import sfr_pkg::*;

    // end of stream always closes the run of its input beat
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[USER_DONE] |-> m_axis_tlast)
        else $error("stream_done without run_last");

    // a bare end marker is a zero byte that ends both the run and the stream
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[USER_PRESENT] |->
            m_axis_tlast && m_axis_tuser[USER_DONE] && (m_axis_tdata == '0))
        else $error("malformed end marker");

    // a stalled result beat holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // nothing is offered in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/tb_top.sv
// self-checking testbench for the stream find-and-replace block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int MAX_RESULTS  = 8;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 40;
    localparam int PRESS_PHASE  = 5;
    localparam int PRESS_ITEMS  = 60;

    // one output beat as seen on the master side
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              present;
        logic              run_last;
        logic              done;
    } t_text_beat;

    // predicts the replaced text and checks the output beats against it
    class find_replace_scoreboard;
        logic [CFG_DATA_W-1:0] pat_word;
        logic [LEN_W-1:0]      pat_len;
        logic [CFG_DATA_W-1:0] rep_word;
        logic [LEN_W-1:0]      rep_len;
        logic [BYTE_W-1:0]     window [PATTERN_MAX_DEF];
        int unsigned           held;
        logic [BYTE_W-1:0]     out_bytes [$];
        t_text_beat            expected_q [$];
        int unsigned           mismatches;

        function new();
            pat_word   = '0;
            pat_len    = '0;
            rep_word   = '0;
            rep_len    = '0;
            held       = 0;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_PATTERN_BYTES:  pat_word = value;
                CFG_PATTERN_LENGTH: pat_len  = value[LEN_W-1:0];
                CFG_REPLACE_BYTES:  rep_word = value;
                CFG_REPLACE_LENGTH: rep_len  = value[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void push_byte(logic [BYTE_W-1:0] b);
            if (out_bytes.size() < MAX_RESULTS)
                out_bytes.push_back(b);
        endfunction

        // pass the oldest k held bytes through and close the gap
        function void pass_oldest(int unsigned k);
            int unsigned n;
            n = (k > held) ? held : k;
            for (int unsigned i = 0; i < n; i++)
                push_byte(window[i]);
            for (int unsigned i = 0; i + n < held; i++)
                window[i] = window[i + n];
            held -= n;
        endfunction

        function void note_input(logic [BYTE_W-1:0] b, logic fin);
            int unsigned plen;
            int unsigned rlen;
            int unsigned n;
            bit          hit;
            t_text_beat  beat;
            plen = (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : pat_len;
            rlen = (rep_len > REPLACE_MAX_DEF) ? REPLACE_MAX_DEF : rep_len;
            out_bytes.delete();
            if (held >= PATTERN_MAX_DEF)
                held = PATTERN_MAX_DEF - 1;
            window[held] = b;
            held++;

            // pass-through, shortened pattern, or full-window compare
            if (plen == 0) begin
                pass_oldest(held);
            end else if (held > plen) begin
                pass_oldest(held - plen + 1);
            end else if (held == plen) begin
                hit = 1'b1;
                for (int unsigned i = 0; i < plen; i++)
                    if (window[i] !== pat_word[8*i +: 8])
                        hit = 1'b0;
                if (hit) begin
                    for (int unsigned i = 0; i < rlen; i++)
                        push_byte(rep_word[8*i +: 8]);
                    held = 0;
                end else begin
                    pass_oldest(1);
                end
            end

            // end of stream flushes whatever is held
            if (fin)
                pass_oldest(held);

            n = out_bytes.size();
            if (fin && n == 0) begin
                beat.data     = '0;
                beat.present  = 1'b0;
                beat.run_last = 1'b1;
                beat.done     = 1'b1;
                expected_q.push_back(beat);
            end else begin
                for (int unsigned i = 0; i < n; i++) begin
                    beat.data     = out_bytes[i];
                    beat.present  = 1'b1;
                    beat.run_last = (i + 1 == n);
                    beat.done     = (i + 1 == n) && fin;
                    expected_q.push_back(beat);
                end
            end
        endfunction

        function string beat_str(t_text_beat bt);
            return $sformatf("data %02h present %0b last %0b done %0b",
                             bt.data, bt.present, bt.run_last, bt.done);
        endfunction

        function void report(string what, t_text_beat want, t_text_beat got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%s: expected %s, got %s", what, beat_str(want), beat_str(got));
        endfunction

        function void check_result(t_text_beat got);
            t_text_beat want;
            if (expected_q.size() == 0) begin
                report("output beat with nothing pending", '0, got);
            end else begin
                want = expected_q.pop_front();
                if (got.data !== want.data || got.present !== want.present ||
                    got.run_last !== want.run_last || got.done !== want.done)
                    report("output beat differs", want, got);
            end
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata  = '0;   // [7:0] in_byte
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]      m_axis_tdata;         // [7:0] out_byte
    logic                   m_axis_tlast;
    logic [USER_W-1:0]      m_axis_tuser;         // [0] byte_present, [1] stream_done

    find_replace_scoreboard sb = new();

    logic [CFG_DATA_W-1:0] cur_pat     = '0;
    int unsigned           cur_plen    = 0;
    int unsigned           idle_cycles = 0;
    bit                    hold_req    = 1'b0;
    bit                    hold_active = 1'b0;

    stream_find_replace u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // beat monitor on both sides, plus the count of cycles with no beat
    always @(posedge i_clk) begin
        t_text_beat got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                got.data     = m_axis_tdata;
                got.present  = m_axis_tuser[USER_PRESENT];
                got.run_last = m_axis_tlast;
                got.done     = m_axis_tuser[USER_DONE];
                sb.check_result(got);
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog
    initial begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("stream_find_replace: mismatch");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic pick_end();
        return ($urandom_range(0, 24) == 0);
    endfunction

    // receiver: ready runs with stalls between, and one long hold-off on request
    initial begin
        int unsigned stall;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req      = 1'b0;
                hold_active   = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active   = 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
                stall = pick_gap();
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // offer one input beat and return at the edge that takes it
    task automatic send_byte(logic [BYTE_W-1:0] b, logic fin, bit tight);
        int unsigned gap;
        gap = tight ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // let every expected beat arrive, then allow for work still in flight
    task automatic wait_idle();
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // send up to eight bytes from a word, lowest byte first
    task automatic send_word(logic [CFG_DATA_W-1:0] w, int unsigned n, bit end_last);
        for (int unsigned i = 0; i < n; i++)
            send_byte(w[8*i +: 8], end_last && (i + 1 == n), 1'b0);
        s_axis_tvalid <= 1'b0;
        wait_idle();
    endtask

    // write all four registers, optionally with junk above the length bits
    task automatic load_config(logic [CFG_DATA_W-1:0] pw, int unsigned pl,
                               logic [CFG_DATA_W-1:0] rw, int unsigned rl);
        logic [CFG_DATA_W-1:0] vals [4];
        t_cfg_reg              idx;
        vals[0] = pw;
        vals[1] = CFG_DATA_W'(pl[LEN_W-1:0]);
        vals[2] = rw;
        vals[3] = CFG_DATA_W'(rl[LEN_W-1:0]);
        if ($urandom_range(0, 3) == 0) begin
            vals[1][CFG_DATA_W-1:LEN_W] = (CFG_DATA_W-LEN_W)'({$urandom, $urandom});
            vals[3][CFG_DATA_W-1:LEN_W] = (CFG_DATA_W-LEN_W)'({$urandom, $urandom});
        end
        i_cfg_we <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            idx = t_cfg_reg'(i);
            i_cfg_index <= idx;
            i_cfg_wdata <= vals[i];
            sb.write_reg(idx, vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cur_pat  = pw;
        cur_plen = (pl[LEN_W-1:0] > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : pl[LEN_W-1:0];
    endtask

    // random text: whole patterns, broken prefixes, near-miss and raw noise
    task automatic run_text(int unsigned n_items, bit tight);
        int unsigned sent;
        int unsigned kind;
        int unsigned cut;
        int unsigned pick;
        logic [BYTE_W-1:0] b;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            if (cur_plen > 0 && kind < 35)
                cut = cur_plen;
            else if (cur_plen > 1 && kind < 50)
                cut = $urandom_range(1, cur_plen - 1);
            else
                cut = 0;
            for (int unsigned i = 0; i < cut; i++) begin
                send_byte(cur_pat[8*i +: 8], pick_end(), tight);
                sent++;
            end
            if (cut != cur_plen || cut == 0 || $urandom_range(0, 1) == 0) begin
                if (cur_plen > 0 && kind < 75) begin
                    pick = $urandom_range(0, cur_plen - 1);
                    b    = cur_pat[8*pick +: 8];
                end else begin
                    b = BYTE_W'($urandom);
                end
                send_byte(b, pick_end(), tight);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        else if (r < 25)
            return 8;
        else if (r < 35)
            return $urandom_range(9, 15);
        else
            return $urandom_range(1, 7);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_word();
        int unsigned           r;
        logic [CFG_DATA_W-1:0] w;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            w = '0;
        end else if (r < 30) begin
            w = '1;
        end else if (r < 60) begin
            // two-letter alphabet gives overlapping partial matches
            for (int i = 0; i < 8; i++)
                w[8*i +: 8] = $urandom_range(0, 1) ? 8'h41 : 8'h42;
        end else begin
            w = {$urandom, $urandom};
        end
        return w;
    endfunction

    // test sequence
    initial begin
        int unsigned pl;
        int unsigned rl;
        bit          tight;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration passes text straight through
        send_word(64'h0000_0000_0000_FF00, 2, 1'b1);

        // match, then a near miss flushed by the end of stream
        load_config(64'h0000_0000_0063_6261, 3, 64'h0000_0056_575A_5958, 5);
        send_word(64'h0000_7A62_6163_6261, 6, 1'b1);

        // all-ones pattern expanding to eight zero bytes, three bytes left held
        load_config(64'h0000_0000_FFFF_FFFF, 4, 64'h0, 8);
        send_word(64'h00FF_FFFF_FFFF_FFFF, 7, 1'b0);

        // pattern shortened with bytes held, then deletion and a bare end marker
        load_config(64'h0000_0000_0000_FFFF, 2, 64'h0, 0);
        send_word(64'h0000_0000_0000_0011, 1, 1'b0);
        send_word(64'h0000_0000_FFFF_FFFF, 4, 1'b1);

        // oversized lengths saturate to eight
        load_config(64'h0, 15, {$urandom, $urandom}, 15);
        send_word(64'h0, 8, 1'b1);

        // random phases, each with its own settings
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       begin pl = 0;  rl = 8;  end
                1:       begin pl = 8;  rl = 0;  end
                2:       begin pl = 15; rl = 1;  end
                3:       begin pl = 1;  rl = 15; end
                default: begin pl = pick_len(); rl = pick_len(); end
            endcase
            load_config(pick_word(), pl, pick_word(), rl);
            tight = ($urandom_range(0, 3) == 0);
            if (ph == PRESS_PHASE) begin
                // output held off while input keeps coming
                hold_req = 1'b1;
                while (!hold_active)
                    @(posedge i_clk);
                run_text(PRESS_ITEMS, 1'b1);
            end else begin
                run_text(PHASE_ITEMS, tight);
            end
            wait_idle();
        end

        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("stream_find_replace: match");
        end else begin
            $display("stream_find_replace: mismatch");
        end
        $finish;
    end

endmodule
